@@ rtl/ctu_pkg.sv @@
// ----------------------------------------------------------------------------
// ctu_pkg: shared types and constants
// Field layout of the stream words, operation and register codes, and the
// command/status bundles between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package ctu_pkg;

	// Operation codes carried in s_axis_tuser
	localparam logic [1:0] OP_WRITE     = 2'd0;
	localparam logic [1:0] OP_TRANSLATE = 2'd1;
	localparam logic [1:0] OP_CLEAR     = 2'd2;

	// Configuration register indexes
	localparam logic REG_ENTRIES_IN_USE = 1'b0;
	localparam logic REG_STAGE_COUNT    = 1'b1;

	// Field widths
	localparam int OP_W       = 2;
	localparam int IDX_W      = 8;
	localparam int STAGE_W    = 3;
	localparam int FIELD_W    = 32;
	localparam int ENTRIES_W  = 9;
	localparam int SCOUNT_W   = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	// Reset value of the stage count register
	localparam logic [SCOUNT_W-1:0] SCOUNT_RST = 4'd7;

	// Input word layout, lowest bits first
	localparam int IDX_LSB    = 0;
	localparam int STAGE_LSB  = IDX_LSB + IDX_W;
	localparam int SRC_LSB    = STAGE_LSB + STAGE_W;
	localparam int DEST_LSB   = SRC_LSB + FIELD_W;
	localparam int LEN_LSB    = DEST_LSB + FIELD_W;
	localparam int QUERY_LSB  = LEN_LSB + FIELD_W;
	localparam int S_TDATA_W  = ((QUERY_LSB + FIELD_W + 7) / 8) * 8;

	// Output word layout
	localparam int LOC_LSB    = 0;
	localparam int LOW_LSB    = FIELD_W;
	localparam int M_TDATA_W  = 2 * FIELD_W;

	// Commands from the sequencer
	typedef struct packed {
		logic write_entry;
		logic load_query;
		logic clear_min;
		logic issue_read;
		logic apply;
		logic next_stage;
		logic finish;
	} ctu_cmd_t;

	// Status from the datapath
	typedef struct packed {
		logic hit;
		logic last_miss;
		logic more;
		logic stage_last;
		logic empty;
		logic out_free;
	} ctu_sts_t;

endpackage

@@ rtl/ctu_ram.sv @@
// ----------------------------------------------------------------------------
// ctu_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ctu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/ctu_datapath.sv @@
// ----------------------------------------------------------------------------
// ctu_datapath: table storage, range compare and result registers
// Holds the configuration registers, the entry table, the walk counters,
// the running value and minimum, and the output word register.
// ----------------------------------------------------------------------------
module ctu_datapath import ctu_pkg::*; #(
	parameter int TABLE_ENTRIES = 256,
	parameter int MAX_STAGES    = 8,
	parameter int VALUE_BITS    = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [S_TDATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,
	input  ctu_cmd_t              cmd,
	output ctu_sts_t              sts
);

	localparam int AW       = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int UCNT_W   = $clog2(TABLE_ENTRIES + 1);
	localparam int STG_W    = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
	localparam int SCNT_W   = $clog2(MAX_STAGES + 1);
	localparam int ST_CMP_W = (STG_W > STAGE_W) ? STG_W : STAGE_W;
	localparam int VW       = VALUE_BITS;
	localparam int EW       = VALUE_BITS + 1;
	// Entry word: {stage, source, end (exclusive), offset}
	localparam int E_OFF_LSB = 0;
	localparam int E_END_LSB = VW;
	localparam int E_SRC_LSB = VW + EW;
	localparam int E_STG_LSB = 2 * VW + EW;
	localparam int ENT_W     = STAGE_W + 2 * VW + EW;

	logic [ENTRIES_W-1:0] cfg_entries_q;
	logic [SCOUNT_W-1:0]  cfg_stages_q;
	logic [UCNT_W-1:0]    used_eff;
	logic [SCNT_W-1:0]    stages_eff;

	logic [IDX_W-1:0]     in_index;
	logic [STAGE_W-1:0]   in_stage;
	logic [VW-1:0]        wr_src;
	logic [VW-1:0]        wr_dest;
	logic [VW-1:0]        wr_len;
	logic [EW-1:0]        wr_end;
	logic [VW-1:0]        wr_off;
	logic [ENT_W-1:0]     wr_word;
	logic                 wr_en;

	logic [UCNT_W-1:0]    addr_q;
	logic [UCNT_W-1:0]    addr_nx;
	logic [STG_W-1:0]     stage_q;
	logic                 rd_vld_s1;
	logic                 rd_last_s1;
	logic [ENT_W-1:0]     rd_word;

	logic [STAGE_W-1:0]   ent_stage;
	logic [VW-1:0]        ent_src;
	logic [EW-1:0]        ent_end;
	logic [VW-1:0]        ent_off;
	logic                 hit;

	logic [VW-1:0]        v_q;
	logic [VW-1:0]        lowest_q;
	logic [VW-1:0]        new_min;
	logic                 m_tvalid_q;
	logic [FIELD_W-1:0]   out_loc_q;
	logic [FIELD_W-1:0]   out_low_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_entries_q <= '0;
			cfg_stages_q  <= SCOUNT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ENTRIES_IN_USE: cfg_entries_q <= cfg_data[ENTRIES_W-1:0];
				REG_STAGE_COUNT:    cfg_stages_q  <= cfg_data[SCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the configured counts to the table and stage limits
	assign used_eff   = (cfg_entries_q > TABLE_ENTRIES) ? UCNT_W'(TABLE_ENTRIES)
	                                                    : UCNT_W'(cfg_entries_q);
	assign stages_eff = (cfg_stages_q > MAX_STAGES) ? SCNT_W'(MAX_STAGES)
	                                                : SCNT_W'(cfg_stages_q);

	// Build the entry word: exclusive end and offset are formed at write time
	assign in_index = s_tdata[IDX_LSB +: IDX_W];
	assign in_stage = s_tdata[STAGE_LSB +: STAGE_W];
	assign wr_src   = VW'(s_tdata[SRC_LSB +: FIELD_W]);
	assign wr_dest  = VW'(s_tdata[DEST_LSB +: FIELD_W]);
	assign wr_len   = VW'(s_tdata[LEN_LSB +: FIELD_W]);
	assign wr_end   = EW'(wr_src) + EW'(wr_len);
	assign wr_off   = wr_dest - wr_src;
	assign wr_word  = {in_stage, wr_src, wr_end, wr_off};
	// Drop writes to slots beyond the table
	assign wr_en    = cmd.write_entry && (in_index < TABLE_ENTRIES);

	ctu_ram #(
		.WIDTH (ENT_W),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (AW'(in_index)),
		.wdata (wr_word),
		.re    (cmd.issue_read),
		.raddr (addr_q[AW-1:0]),
		.rdata (rd_word)
	);

	// Walk counters: entry address and stage number
	assign addr_nx = addr_q + UCNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q    <= '0;
			stage_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.issue_read;
			if (cmd.load_query) begin
				addr_q  <= '0;
				stage_q <= '0;
			end else if (cmd.next_stage) begin
				addr_q  <= '0;
				stage_q <= stage_q + STG_W'(1);
			end else if (cmd.issue_read) begin
				addr_q  <= addr_nx;
			end
		end
	end

	// Mark the read of the last entry in use
	always_ff @(posedge clk) begin
		if (cmd.issue_read) begin
			rd_last_s1 <= (addr_nx == used_eff);
		end
	end

	// Range compare on the entry read last cycle
	assign ent_stage = rd_word[E_STG_LSB +: STAGE_W];
	assign ent_src   = rd_word[E_SRC_LSB +: VW];
	assign ent_end   = rd_word[E_END_LSB +: EW];
	assign ent_off   = rd_word[E_OFF_LSB +: VW];
	assign hit = rd_vld_s1
	          && (ST_CMP_W'(ent_stage) == ST_CMP_W'(stage_q))
	          && (v_q >= ent_src)
	          && (EW'(v_q) < ent_end);

	// Running value
	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			v_q <= VW'(s_tdata[QUERY_LSB +: FIELD_W]);
		end else if (cmd.apply) begin
			v_q <= v_q + ent_off;
		end
	end

	// Running minimum
	assign new_min = (v_q < lowest_q) ? v_q : lowest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_q <= '1;
		end else if (cmd.clear_min) begin
			lowest_q <= '1;
		end else if (cmd.finish) begin
			lowest_q <= new_min;
		end
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_loc_q <= FIELD_W'(v_q);
			out_low_q <= FIELD_W'(new_min);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_low_q, out_loc_q};

	// Status to the sequencer
	always_comb begin
		sts            = '0;
		sts.hit        = hit;
		sts.last_miss  = rd_vld_s1 && rd_last_s1 && !hit;
		sts.more       = (addr_q < used_eff);
		sts.stage_last = ((SCNT_W'(stage_q) + SCNT_W'(1)) == stages_eff);
		sts.empty      = (used_eff == '0) || (stages_eff == '0);
		sts.out_free   = !m_tvalid_q || m_tready;
	end

	// A new stage restarts at the first entry with no read in flight
	a_stage_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.next_stage |=> (addr_q == '0) && !rd_vld_s1)
		else $error("stage restart left a read in flight");

	// Emitting a result never raises the running minimum
	a_min_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && !cmd.clear_min |=> lowest_q <= $past(lowest_q))
		else $error("running minimum increased");

	// A held result word is not overwritten
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !m_tvalid_q || m_tready)
		else $error("result overwritten while waiting");

endmodule

@@ rtl/ctu_ctrl.sv @@
// ----------------------------------------------------------------------------
// ctu_ctrl: item sequencer
// Decodes accepted words and walks the table stage by stage, one entry
// read per cycle, until each stage hits or runs out of entries.
// ----------------------------------------------------------------------------
module ctu_ctrl import ctu_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [OP_W-1:0] s_tuser,
	output ctu_cmd_t        cmd,
	input  ctu_sts_t        sts
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Next state and commands
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		s_tready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (s_tuser)
						OP_WRITE: cmd.write_entry = 1'b1;
						OP_TRANSLATE: begin
							cmd.load_query = 1'b1;
							state_d = sts.empty ? ST_FINISH : ST_SCAN;
						end
						OP_CLEAR: cmd.clear_min = 1'b1;
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				if (sts.hit || sts.last_miss) begin
					cmd.apply = sts.hit;
					if (sts.stage_last) begin
						state_d = ST_FINISH;
					end else begin
						cmd.next_stage = 1'b1;
					end
				end else begin
					cmd.issue_read = sts.more;
				end
			end
			ST_FINISH: begin
				// Hold until the output register can take the word
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// No further read once the current stage is decided
	a_no_read_after_decide: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue_read |-> !sts.hit && !sts.last_miss)
		else $error("read issued after stage decided");

	// A decided stage that is not the last keeps scanning
	a_scan_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) && (sts.hit || sts.last_miss) && !sts.stage_last
		|=> state_q == ST_SCAN)
		else $error("scan left early");

	// An accepted translate word always leaves idle
	a_translate_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_TRANSLATE) |=> state_q != ST_IDLE)
		else $error("translate word not started");

endmodule

@@ rtl/chained_range_translation_unit.sv @@
// Write and clear words are handled while idle; op code 3 is accepted and dropped.
// A translate word walks each stage's entries until a hit or the last
// entry in use, and no new word is taken until its result is registered;
// the table RAM read port delivers one entry per cycle and a stage stops at its first hit.
// Reset clears configuration to defaults and the minimum to all ones;
// table contents are not cleared.
// ----------------------------------------------------------------------------
// chained_range_translation_unit: chained range offset translation table
// Stream in table writes, translate requests and minimum clears; stream out
// the translated location with the running minimum.
// ----------------------------------------------------------------------------
module chained_range_translation_unit import ctu_pkg::*; #(
	parameter int TABLE_ENTRIES = 256,
	parameter int MAX_STAGES    = 8,
	parameter int VALUE_BITS    = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write port
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// Input words
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// entry_index, entry_stage, entry_source, entry_dest, entry_length,
	// query_value, zero pad
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,
	// operation
	input  logic [OP_W-1:0]       s_axis_tuser,
	// Result words
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// location, lowest_location
	output logic [M_TDATA_W-1:0]  m_axis_tdata
);

	ctu_cmd_t cmd;
	ctu_sts_t sts;

	ctu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.s_tuser  (s_axis_tuser),
		.cmd      (cmd),
		.sts      (sts)
	);

	ctu_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.MAX_STAGES    (MAX_STAGES),
		.VALUE_BITS    (VALUE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_axis_tdata),
		.m_tvalid  (m_axis_tvalid),
		.m_tready  (m_axis_tready),
		.m_tdata   (m_axis_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
